// ===== rtl/bfs_pkg.sv =====
// Shared constants, state encoding and controller/datapath interface types.
`default_nettype none

package bfs_pkg;

    localparam int ALPHABET = 256;
    localparam int MAX_LEN  = 4096;

    localparam int SYM_W  = 8;
    localparam int ADDR_W = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int CNT_W  = $clog2(MAX_LEN + 1);

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD_RD,
        ST_LD_WR,
        ST_SCAN,
        ST_TAIL,
        ST_PICK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic rd_scan;
        logic scan_start;
        logic ld_write;
        logic set_ovf;
        logic pick;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic total_zero;
        logic group_zero;
        logic sym_ok;
        logic full;
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/bfs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/bfs_ctrl.sv =====
// Controller state machine: sequences loads, histogram scans and result issue.
`default_nettype none

module bfs_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    input  wire logic            s_func,
    output logic                 s_ready,
    input  wire bfs_pkg::status_t sts,
    output bfs_pkg::cmd_t        cmd
);

    import bfs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    if (s_func == FUNC_LOAD) begin
                        state_next = ST_LD_RD;
                    end else if (sts.total_zero) begin
                        state_next = ST_EMIT;
                    end else if (sts.group_zero) begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_LD_RD: begin
                // drop out-of-alphabet bytes silently, flag bytes beyond capacity
                priority if (!sts.sym_ok) begin
                    state_next = ST_IDLE;
                end else if (sts.full) begin
                    cmd.set_ovf = 1'b1;
                    state_next  = ST_IDLE;
                end else begin
                    state_next = ST_LD_WR;
                end
            end
            ST_LD_WR: begin
                cmd.ld_write = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_SCAN: begin
                cmd.rd_scan = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: begin
                state_next = ST_PICK;
            end
            ST_PICK: begin
                cmd.pick   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/bfs_dp.sv =====
// Datapath: histogram memory, scan comparator, group counters and result register.
`default_nettype none

module bfs_dp (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [bfs_pkg::SYM_W-1:0] s_symbol,
    input  wire bfs_pkg::cmd_t            cmd,
    output bfs_pkg::status_t              sts,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [bfs_pkg::SYM_W-1:0]     m_out_symbol,
    output logic                          m_last,
    output logic                          m_none_left,
    output logic                          m_overflowed
);

    import bfs_pkg::*;

    logic [SYM_W-1:0]    sym_reg;
    logic [ALPHABET-1:0] valid_reg;
    logic                rd_valid_reg;
    logic [ADDR_W-1:0]   rd_addr;
    logic [CNT_W-1:0]    ram_rdata;
    logic [CNT_W-1:0]    cnt_rd;
    logic [ADDR_W-1:0]   sym_addr;

    logic [ADDR_W-1:0]   scan_idx_reg;
    logic [ADDR_W-1:0]   cmp_addr_reg;
    logic                cmp_en_reg;
    logic [ADDR_W-1:0]   best_sym_reg;
    logic [CNT_W-1:0]    best_cnt_reg;

    logic [ADDR_W-1:0]   group_sym_reg;
    logic [CNT_W-1:0]    group_rem_reg;
    logic [CNT_W-1:0]    total_reg;
    logic                ovf_reg;

    logic                m_valid_reg;
    logic [SYM_W-1:0]    out_sym_reg;
    logic                last_reg;
    logic                none_reg;
    logic                ovf_out_reg;

    assign sym_addr = sym_reg[ADDR_W-1:0];
    assign rd_addr  = cmd.rd_scan ? scan_idx_reg : sym_addr;
    assign cnt_rd   = rd_valid_reg ? ram_rdata : '0;

    bfs_ram #(
        .WIDTH(CNT_W),
        .DEPTH(ALPHABET)
    ) u_hist (
        .aclk (aclk),
        .we   (cmd.ld_write),
        .waddr(sym_addr),
        .wdata(cnt_rd + CNT_W'(1)),
        .raddr(rd_addr),
        .rdata(ram_rdata)
    );

    assign sts.total_zero = (total_reg == '0);
    assign sts.group_zero = (group_rem_reg == '0);
    assign sts.sym_ok     = ({1'b0, sym_reg} < (SYM_W + 1)'(ALPHABET));
    assign sts.full       = (total_reg >= CNT_W'(MAX_LEN));
    assign sts.scan_last  = (scan_idx_reg == ADDR_W'(ALPHABET - 1));
    assign sts.out_free   = !m_valid_reg || m_ready;

    // Unwritten entries read as zero through the valid bits.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sym_reg <= s_symbol;
        end
        rd_valid_reg <= valid_reg[rd_addr];
        cmp_addr_reg <= scan_idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            scan_idx_reg  <= '0;
            cmp_en_reg    <= 1'b0;
            best_sym_reg  <= '0;
            best_cnt_reg  <= '0;
            group_sym_reg <= '0;
            group_rem_reg <= '0;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cmp_en_reg <= cmd.rd_scan;

            if (cmd.scan_start) begin
                scan_idx_reg <= '0;
                best_sym_reg <= '0;
                best_cnt_reg <= '0;
            end else if (cmd.rd_scan) begin
                scan_idx_reg <= scan_idx_reg + ADDR_W'(1);
            end

            // keep the smallest nonzero count; strict compare keeps the lower symbol
            if (cmp_en_reg && cnt_rd != '0 &&
                (best_cnt_reg == '0 || cnt_rd < best_cnt_reg)) begin
                best_sym_reg <= cmp_addr_reg;
                best_cnt_reg <= cnt_rd;
            end

            if (cmd.ld_write) begin
                valid_reg[sym_addr] <= 1'b1;
                total_reg           <= total_reg + CNT_W'(1);
            end

            if (cmd.set_ovf) begin
                ovf_reg <= 1'b1;
            end

            if (cmd.pick) begin
                group_sym_reg           <= best_sym_reg;
                group_rem_reg           <= best_cnt_reg;
                valid_reg[best_sym_reg] <= 1'b0;
            end

            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
                if (total_reg == '0 || group_rem_reg == '0) begin
                    total_reg <= '0;
                    ovf_reg   <= 1'b0;
                end else begin
                    group_rem_reg <= group_rem_reg - CNT_W'(1);
                    total_reg     <= total_reg - CNT_W'(1);
                    if (total_reg == CNT_W'(1)) begin
                        ovf_reg <= 1'b0;
                    end
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            ovf_out_reg <= ovf_reg;
            if (total_reg == '0 || group_rem_reg == '0) begin
                out_sym_reg <= '0;
                last_reg    <= 1'b0;
                none_reg    <= 1'b1;
            end else begin
                out_sym_reg <= SYM_W'(group_sym_reg);
                last_reg    <= (total_reg == CNT_W'(1));
                none_reg    <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_symbol = out_sym_reg;
    assign m_last       = last_reg;
    assign m_none_left  = none_reg;
    assign m_overflowed = ovf_out_reg;

endmodule

`default_nettype wire

// ===== rtl/byte_frequency_sorter.sv =====
// Top level of the byte frequency sorter: controller plus datapath.
`default_nettype none

// Byte frequency sorter. Each input transaction either loads one byte
// (s_func = 0) into a per-value histogram or requests the next output byte
// (s_func = 1). Loads produce no result transaction; every drain request
// produces exactly one. Output bytes come grouped by value, groups in
// ascending count order, equal counts by ascending byte value. m_last marks
// the final stored byte; m_none_left marks a request that found nothing
// stored (m_out_symbol is then 0). m_overflowed reports bytes dropped after
// MAX_LEN were stored; the flag clears after it is shown on an m_last or
// m_none_left result. A load reads, then writes, its histogram entry; a
// byte dropped because the histogram is full skips the write. A drain
// inside a group, or one that finds nothing stored, goes straight to
// issue; a drain that opens a new group walks the whole histogram memory,
// one entry per cycle through its single read port, before pick and issue.
// The block takes one transaction at a time; a finished result sits in the
// output register while the next transaction is accepted, and a drain
// waits only if that register is still occupied.
module byte_frequency_sorter (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_func,
    input  wire logic [bfs_pkg::SYM_W-1:0] s_symbol,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [bfs_pkg::SYM_W-1:0]      m_out_symbol,
    output logic                           m_last,
    output logic                           m_none_left,
    output logic                           m_overflowed
);

    import bfs_pkg::*;

    cmd_t    cmd;
    status_t sts;

    // Sequence each transaction through load, scan, pick and issue steps.
    bfs_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_func (s_func),
        .s_ready(s_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    // Hold the histogram, group counters and the result register.
    bfs_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_symbol    (s_symbol),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_symbol(m_out_symbol),
        .m_last      (m_last),
        .m_none_left (m_none_left),
        .m_overflowed(m_overflowed)
    );

endmodule

`default_nettype wire

// ===== test/byte_frequency_sorter_test.sv =====
// Self-checking testbench for the byte frequency sorter: random and directed load/drain traffic.
`timescale 1ns / 1ps

typedef struct packed {
    logic [bfs_pkg::SYM_W-1:0] sym;
    logic                      last;
    logic                      none_left;
    logic                      overflowed;
} sorted_byte_t;

// Keep a shadow histogram and queue the sorted bytes each drain must return.
class sorter_scoreboard;
    logic [bfs_pkg::CNT_W-1:0] counts [bfs_pkg::ALPHABET];
    logic [bfs_pkg::SYM_W-1:0] run_symbol;
    logic [bfs_pkg::CNT_W-1:0] run_left;
    logic [bfs_pkg::CNT_W-1:0] stored;
    logic                      dropped;
    sorted_byte_t              pending [$];
    int                        failures;

    function new();
        foreach (counts[i]) counts[i] = '0;
        run_symbol = '0;
        run_left   = '0;
        stored     = '0;
        dropped    = 1'b0;
        failures   = 0;
    endfunction

    function void note_input(logic func, logic [bfs_pkg::SYM_W-1:0] sym);
        sorted_byte_t res;
        int           best;
        int           v;
        if (func == bfs_pkg::FUNC_LOAD) begin
            if (int'(sym) < bfs_pkg::ALPHABET) begin
                if (int'(stored) >= bfs_pkg::MAX_LEN) begin
                    dropped = 1'b1;
                end else begin
                    counts[sym] = counts[sym] + bfs_pkg::CNT_W'(1);
                    stored      = stored + bfs_pkg::CNT_W'(1);
                end
            end
            return;
        end
        res = '0;
        // Open the next group: smallest nonzero count, lowest value on ties.
        if (stored != 0 && run_left == 0) begin
            best = -1;
            for (v = 0; v < bfs_pkg::ALPHABET; v++) begin
                if (counts[v] != 0 && (best < 0 || counts[v] < counts[best])) best = v;
            end
            if (best >= 0) begin
                run_symbol   = best[bfs_pkg::SYM_W-1:0];
                run_left     = counts[best];
                counts[best] = '0;
            end
        end
        if (stored == 0 || run_left == 0) begin
            stored         = '0;
            res.none_left  = 1'b1;
            res.overflowed = dropped;
            dropped        = 1'b0;
        end else begin
            run_left       = run_left - bfs_pkg::CNT_W'(1);
            stored         = stored - bfs_pkg::CNT_W'(1);
            res.sym        = run_symbol;
            res.last       = (stored == 0);
            res.overflowed = dropped;
            if (stored == 0) dropped = 1'b0;
        end
        pending.push_back(res);
    endfunction

    function void check_result(sorted_byte_t got);
        sorted_byte_t want;
        if (pending.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("unexpected output transaction: ",
                         "sym=%02h last=%0b none_left=%0b ovf=%0b",
                         got.sym, got.last, got.none_left, got.overflowed);
            return;
        end
        want = pending.pop_front();
        if (got.sym !== want.sym || got.last !== want.last ||
            got.none_left !== want.none_left || got.overflowed !== want.overflowed) begin
            failures++;
            if (failures <= 10)
                $display("mismatch: expected sym=%02h last=%0b none_left=%0b ovf=%0b,",
                         " got sym=%02h last=%0b none_left=%0b ovf=%0b",
                         want.sym, want.last, want.none_left, want.overflowed,
                         got.sym, got.last, got.none_left, got.overflowed);
        end
    endfunction
endclass

module byte_frequency_sorter_test;
    import bfs_pkg::*;

    // A group open walks all 256 entries; the hold-off must outlast it.
    localparam int HOLD_CYCLES  = 600;
    localparam int SETTLE       = 300;
    localparam int RANDOM_ITEMS = 1000;
    localparam int CYCLE_LIMIT  = 4_000_000;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_valid  = 1'b0;
    logic               s_func   = FUNC_LOAD;
    logic [SYM_W-1:0]   s_symbol = '0;
    logic               s_ready;
    logic               m_valid;
    logic               m_ready  = 1'b0;
    logic [SYM_W-1:0]   m_out_symbol;
    logic               m_last;
    logic               m_none_left;
    logic               m_overflowed;

    sorter_scoreboard   sb;
    int                 accepted      = 0;
    int unsigned        cycles        = 0;
    bit                 calm          = 1'b0;  // no idling on either side while set
    int                 holds_asked   = 0;
    int                 holds_granted = 0;
    int                 hold_left     = 0;

    byte_frequency_sorter dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_symbol     (s_symbol),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_symbol (m_out_symbol),
        .m_last       (m_last),
        .m_none_left  (m_none_left),
        .m_overflowed (m_overflowed)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) cycles <= cycles + 1;

    // Hang guard: abort well past the slowest legal run.
    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Result side: drive ready at the falling edge. A requested hold-off loads
    // hold_left from HOLD_CYCLES and keeps ready low until it runs out, so the
    // output register backs up and the block stops taking drain requests.
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_granted != holds_asked) begin
            m_ready       <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            holds_granted <= holds_granted + 1;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 21);
        end
    end

    // Check every output transaction against the oldest predicted byte.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_out_symbol, m_last, m_none_left, m_overflowed});
    end

    // Offer one transaction. Enter and leave at a falling edge; valid stays
    // high on return so back-to-back transactions need no extra edge.
    task automatic send_item(input logic func, input logic [SYM_W-1:0] sym);
        while (!calm && $urandom_range(99) < 21) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_func   <= func;
        s_symbol <= sym;
        s_valid  <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sb.note_input(func, sym);
        accepted++;
        @(negedge aclk);
    endtask

    // Drop valid and hold the input side until every predicted byte is out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending.size() != 0);
    endtask

    // Drain until the histogram is empty, slipping in loads now and then,
    // half of them with the value of the group being emitted.
    task automatic drain_all();
        logic [SYM_W-1:0] sym;
        while (sb.stored != 0) begin
            if ($urandom_range(9) == 0) begin
                sym = $urandom_range(1) ? sb.run_symbol : SYM_W'($urandom_range(255));
                send_item(FUNC_LOAD, sym);
            end else begin
                send_item(FUNC_DRAIN, SYM_W'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        int               start;
        int               n;
        int               span;
        int               base;
        int               pick;
        bit               hold_done;
        logic [SYM_W-1:0] sym;

        sb = new();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: drain on an empty histogram first.
        send_item(FUNC_DRAIN, 8'hff);
        // Extreme values with equal counts, plus a single that must lead.
        send_item(FUNC_LOAD, 8'hff);
        send_item(FUNC_LOAD, 8'h00);
        send_item(FUNC_LOAD, 8'hff);
        send_item(FUNC_LOAD, 8'h00);
        send_item(FUNC_LOAD, 8'h07);
        send_item(FUNC_DRAIN, 8'h00);
        send_item(FUNC_DRAIN, 8'h00);
        // Load the value of the open group mid-drain: it forms a group of its own.
        send_item(FUNC_LOAD, 8'h00);
        repeat (5) send_item(FUNC_DRAIN, 8'h55);
        // Tie on count: the lower value goes first.
        send_item(FUNC_LOAD, 8'h03);
        send_item(FUNC_LOAD, 8'h03);
        send_item(FUNC_LOAD, 8'h01);
        send_item(FUNC_LOAD, 8'h01);
        repeat (5) send_item(FUNC_DRAIN, 8'haa);
        wait_drained();

        // Capacity: fill to MAX_LEN, push past it, then drain everything with
        // the result side held off for a while so the input stalls.
        repeat (MAX_LEN) send_item(FUNC_LOAD, SYM_W'($urandom_range(255)));
        repeat (3) send_item(FUNC_LOAD, SYM_W'($urandom_range(255)));
        send_item(FUNC_DRAIN, 8'h00);
        send_item(FUNC_LOAD, 8'h5a);
        send_item(FUNC_LOAD, 8'ha5);
        holds_asked++;
        drain_all();
        send_item(FUNC_DRAIN, 8'h00);
        wait_drained();

        // Random: mostly load bursts drained to the end, some mixed noise and
        // pauses. Narrow spans give repeats and ties; wide spans give many groups.
        start     = accepted;
        hold_done = 1'b0;
        while (accepted - start < RANDOM_ITEMS) begin
            calm = (accepted - start >= 300) && (accepted - start < 450);
            pick = $urandom_range(9);
            if (pick <= 6) begin
                n = ($urandom_range(7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
                case ($urandom_range(3))
                    0: span = 1;
                    1: span = 4;
                    2: span = 16;
                    default: span = 256;
                endcase
                base = $urandom_range(255);
                repeat (n) begin
                    sym = SYM_W'(base + $urandom_range(span - 1));
                    send_item(FUNC_LOAD, sym);
                end
                if (!hold_done && accepted - start > 600) begin
                    holds_asked++;
                    hold_done = 1'b1;
                end
                drain_all();
                if ($urandom_range(3) == 0) send_item(FUNC_DRAIN, SYM_W'($urandom_range(255)));
            end else if (pick <= 8) begin
                repeat ($urandom_range(1, 12))
                    send_item(logic'($urandom_range(1)), SYM_W'($urandom_range(255)));
            end else begin
                wait_drained();
            end
        end
        calm = 1'b0;

        // Let the last results out, then give a group scan time to finish.
        wait_drained();
        repeat (SETTLE) @(negedge aclk);

        if (sb.failures == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
